// ----- rtl/core/usdt_pkg.sv -----
// Shared types and command codes for the unissued store dependence tracker.
// Used by usdt_cell and unissued_store_dependence_tracker; depends on nothing.
package usdt_pkg;

   localparam int SEQ_W = 32;

   // Command codes of a request
   localparam logic [2:0] CMD_INSERT = 3'd0;
   localparam logic [2:0] CMD_CHECK  = 3'd1;
   localparam logic [2:0] CMD_ISSUED = 3'd2;
   localparam logic [2:0] CMD_SQUASH = 3'd3;
   localparam logic [2:0] CMD_CLEAR  = 3'd4;

   typedef struct packed {
      logic [2:0]       command;
      logic [SEQ_W-1:0] seq_num;
   } req_type;

   typedef struct packed {
      logic [SEQ_W-1:0] store_seq;
      logic             has_store;
      logic             last;
      logic             dropped;
   } rsp_type;

   // Broadcast control from the sequencer to every cell of the chain
   typedef struct packed {
      logic             shift;   // walk step: move left by one
      logic             keep;    // walk step: head goes back in at the tail
      logic             insert;  // append wdata at the end of the list
      logic [SEQ_W-1:0] wdata;
      logic [SEQ_W-1:0] head;
   } cell_ctrl_type;

endpackage

// ----- rtl/core/usdt_cell.sv -----
// One entry of the store chain: holds a sequence number and takes its
// right neighbor's value on a walk step. Depends on usdt_pkg.
module usdt_cell (
   input  logic                       clock,
   input  usdt_pkg::cell_ctrl_type    ctrl,
   input  logic                       at_tail,
   input  logic                       at_end,
   input  logic [usdt_pkg::SEQ_W-1:0] right_val,
   output logic [usdt_pkg::SEQ_W-1:0] val
);

   logic [usdt_pkg::SEQ_W-1:0] val_ff;
   logic [usdt_pkg::SEQ_W-1:0] val_in;

   // Pick next value: shift, recirculate head at tail, append, or hold
   always_comb begin
      val_in = val_ff;
      if (ctrl.shift) begin
         val_in = (at_tail && ctrl.keep) ? ctrl.head : right_val;
      end else if (ctrl.insert && at_end) begin
         val_in = ctrl.wdata;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign val = val_ff;

endmodule

// ----- rtl/core/unissued_store_dependence_tracker.sv -----
// Top level of the unissued store dependence tracker: sequencer and chain.
// Depends on usdt_pkg and usdt_cell.
//
// Usage: a request (req_data) is taken at a clock edge with start high and
// busy low. Results come on rsp_data for one cycle each, marked by
// rsp_strobe; the receiver cannot stall them. csr_* writes the optimistic
// bit (csr_ready is always high); write it only while the block is idle.
// The held stores sit oldest first in a chain of CAPACITY cells. Insert and
// clear do not raise busy; insert's result appears the cycle after acceptance.
// Check, issued and squash walk the list: every cycle the head leaves cell 0,
// the chain moves left by one and the head re-enters at the tail if kept.
// A walk keeps busy high while each held store passes once; a check emits one
// result per cycle, the first after the state and then the response register.
// A check of an empty list, or in optimistic mode, gives one empty result the
// cycle after acceptance; issued or squash then do not walk. The walk length is
// set by the chain passing one entry per cycle through the single head compare.
// Reset empties the list and clears the optimistic bit; no clearing pass.
module unissued_store_dependence_tracker #(
   parameter int CAPACITY = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  usdt_pkg::req_type req_data,
   output logic              rsp_strobe,
   output usdt_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_wdata
);

   localparam int LW = $clog2(CAPACITY + 1);
   localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

   typedef enum logic {ST_IDLE, ST_WALK} state_type;

   state_type                  state_ff, state_in;
   logic [LW-1:0]              len_ff, len_in;
   logic [LW-1:0]              remain_ff, remain_in;
   logic [2:0]                 walk_cmd_ff, walk_cmd_in;
   logic [usdt_pkg::SEQ_W-1:0] bound_ff, bound_in;
   logic                       optimistic_ff, optimistic_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   usdt_pkg::rsp_type          rsp_ff, rsp_in;

   usdt_pkg::cell_ctrl_type    ctrl;
   logic [usdt_pkg::SEQ_W-1:0] cell_val [CAPACITY];
   logic [usdt_pkg::SEQ_W-1:0] head;
   logic                       keep;
   logic                       accept;

   assign head   = cell_val[0];
   assign accept = start && (state_ff == ST_IDLE);

   // Decide whether the head survives this walk step
   always_comb begin
      unique case (walk_cmd_ff)
         usdt_pkg::CMD_CHECK:  keep = 1'b1;
         usdt_pkg::CMD_ISSUED: keep = (head != bound_ff);
         default:              keep = (head <= bound_ff);
      endcase
   end

   // Sequencer next state
   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      remain_in     = remain_ff;
      walk_cmd_in   = walk_cmd_ff;
      bound_in      = bound_ff;
      optimistic_in = optimistic_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = '0;
      ctrl          = '0;
      ctrl.head     = head;
      ctrl.wdata    = req_data.seq_num;
      ctrl.keep     = keep;

      if (csr_valid) begin
         optimistic_in = csr_wdata;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.command) inside
                  usdt_pkg::CMD_INSERT: begin
                     rsp_valid_in = 1'b1;
                     rsp_in.last  = 1'b1;
                     if (!optimistic_ff) begin
                        if (len_ff < CAP_L) begin
                           ctrl.insert = 1'b1;
                           len_in      = len_ff + LW'(1);
                        end else begin
                           rsp_in.dropped = 1'b1;
                        end
                     end
                  end
                  usdt_pkg::CMD_CHECK: begin
                     if (optimistic_ff || len_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_in.last  = 1'b1;
                     end else begin
                        state_in    = ST_WALK;
                        remain_in   = len_ff;
                        walk_cmd_in = req_data.command;
                     end
                  end
                  usdt_pkg::CMD_ISSUED, usdt_pkg::CMD_SQUASH: begin
                     if (!optimistic_ff && len_ff != '0) begin
                        state_in    = ST_WALK;
                        remain_in   = len_ff;
                        walk_cmd_in = req_data.command;
                        bound_in    = req_data.seq_num;
                     end
                  end
                  usdt_pkg::CMD_CLEAR: begin
                     len_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            // Advance the chain by one entry; drop the head if not kept
            ctrl.shift = 1'b1;
            if (!keep) begin
               len_in = len_ff - LW'(1);
            end
            remain_in = remain_ff - LW'(1);
            if (walk_cmd_ff == usdt_pkg::CMD_CHECK) begin
               rsp_valid_in     = 1'b1;
               rsp_in.store_seq = head;
               rsp_in.has_store = 1'b1;
               rsp_in.last      = (remain_ff == LW'(1));
            end
            if (remain_ff == LW'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         len_ff        <= '0;
         remain_ff     <= '0;
         optimistic_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         len_ff        <= len_in;
         remain_ff     <= remain_in;
         optimistic_ff <= optimistic_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      walk_cmd_ff <= walk_cmd_in;
      bound_ff    <= bound_in;
      rsp_ff      <= rsp_in;
   end

   // Chain of entry cells, oldest at index 0
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [usdt_pkg::SEQ_W-1:0] right_val;
      if (i == CAPACITY - 1) begin : g_end
         assign right_val = '0;
      end else begin : g_mid
         assign right_val = cell_val[i+1];
      end
      usdt_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .at_tail   (len_ff == LW'(i + 1)),
         .at_end    (len_ff == LW'(i)),
         .right_val (right_val),
         .val       (cell_val[i])
      );
   end

   assign busy       = (state_ff == ST_WALK);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign csr_ready  = 1'b1;

   // Checks on the sequencer
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= CAP_L)
      else $error("list length exceeds capacity");

   a_walk_remain: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> remain_ff != '0 && remain_ff <= len_ff)
      else $error("walk count out of range");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.dropped |-> $past(len_ff) == CAP_L)
      else $error("store dropped with room in list");

   a_store_from_walk: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.has_store |-> $past(state_ff) == ST_WALK)
      else $error("listed store reported outside a walk");

endmodule
